FILE: sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and codes of the process threat correlator
// Event and result items, status codes, flag bits and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  // Event sources
  localparam logic [1:0] MODE_HOOK  = 2'd0;
  localparam logic [1:0] MODE_SCAN  = 2'd1;
  localparam logic [1:0] MODE_MATCH = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Hook kinds
  localparam logic [2:0] API_ALLOC_EX = 3'd1;
  localparam logic [2:0] API_WRITE    = 3'd2;
  localparam logic [2:0] API_PROT     = 3'd3;
  localparam logic [2:0] API_PROT_EX  = 3'd4;
  localparam logic [2:0] API_THREAD   = 3'd6;

  // Scanner finding kinds
  localparam logic [2:0] FIND_REFLECT = 3'd2;
  localparam logic [2:0] FIND_CAVE    = 3'd3;
  localparam logic [2:0] FIND_STOMP   = 3'd4;

  // Entry flag bits
  localparam int unsigned F_ALLOC  = 0;
  localparam int unsigned F_WRITE  = 1;
  localparam int unsigned F_PROT   = 2;
  localparam int unsigned F_THREAD = 3;
  localparam int unsigned F_MATCH  = 4;

  // Region sources
  localparam logic [1:0] SRC_ALLOC = 2'd0;
  localparam logic [1:0] SRC_WRITE = 2'd1;
  localparam logic [1:0] SRC_PROT  = 2'd2;

  // Stored severity: 0..3, or none
  localparam logic [2:0] SEV_NONE = 3'd4;
  localparam logic [1:0] SEV_CRIT = 2'd3;
  localparam logic [2:0] CHAIN_MAX = 3'd7;

  // Register address of kill_enable (word index)
  localparam logic REG_KILL_EN = 1'b0;

  typedef enum logic [2:0] {
    ST_NO_CHANGE = 3'd0,
    ST_VERDICT   = 3'd1,
    ST_LATE      = 3'd2,
    ST_DEDUP     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_REGION,
    S_EVAL,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] pid;
    logic [2:0]  api_kind;
    logic [2:0]  finding_kind;
    logic [31:0] prot_word;
    logic [63:0] address;
    logic [63:0] region_size;
  } evt_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] severity;
    logic       kill_request;
    logic [2:0] chain_step;
    logic [8:0] entry_slot;
  } res_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [1:0]  source;
  } region_t;

endpackage

`default_nettype wire

FILE: sv/ptc_if.sv
// ----------------------------------------------------------------------------
// ptc_if: valid/ready channels of the process threat correlator
// Event channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_evt_if;
  logic          valid;
  logic          ready;
  ptc_pkg::evt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptc_res_if;
  logic          valid;
  logic          ready;
  ptc_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/process_threat_correlator.sv
// ----------------------------------------------------------------------------
// process_threat_correlator: per-process event correlation and verdicts
// Finds or claims a table entry per pid, tracks regions and flags, reports
// severity rises, late evidence, deduplicated findings and a full table.
// ----------------------------------------------------------------------------
// One event at a time: the block scans the occupied part of the process
// table through its single read port, one entry a cycle, then updates the
// entry. A code-cave or module-stomp finding adds a scan of the entry's
// recorded regions, one region a cycle through the subtract-and-compare
// unit. Each result is held until the result port takes it.
// The table needs no clearing after reset: entries are claimed in order, so
// a fill count marks the valid ones.
`default_nettype none

module process_threat_correlator #(
  parameter int unsigned TABLE_ENTRIES     = 512,
  parameter int unsigned REGIONS_PER_ENTRY = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ptc_evt_if.sink           in_i,
  ptc_res_if.source         out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ptc_pkg::*;

  localparam int unsigned SW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned RW  = (REGIONS_PER_ENTRY > 1) ? $clog2(REGIONS_PER_ENTRY) : 1;
  localparam int unsigned RCW = $clog2(REGIONS_PER_ENTRY + 1);
  localparam int unsigned RDEPTH = TABLE_ENTRIES * (2 ** RW);

  typedef struct packed {
    logic [31:0]    pid;
    logic [2:0]     sev;
    logic [4:0]     flags;
    logic [RCW-1:0] rcount;
    logic [2:0]     chain;
  } entry_t;

  // Storage
  entry_t  entry_mem [TABLE_ENTRIES];
  region_t region_mem [RDEPTH];

  state_e         state_q, state_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           rdv_q, rdv_d;
  logic [SW-1:0]  rdidx_q, rdidx_d;
  logic [RCW-1:0] ridx_q, ridx_d;
  logic           rrdv_q, rrdv_d;
  evt_t           evt_q, evt_d;
  logic [SW-1:0]  slot_q, slot_d;
  entry_t         rec_q, rec_d;
  res_t           res_q, res_d;
  logic           kill_en_q;

  entry_t         ent_rd_q;
  region_t        reg_rd_q;
  logic           ent_we;
  logic [SW-1:0]  ent_raddr;
  region_t        reg_wdata;
  logic           reg_we;
  logic [SW+RW-1:0] reg_waddr, reg_raddr;

  // Evaluation and compare helpers
  logic           exec_bit;
  logic           hit;
  logic [63:0]    offset;
  logic [1:0]     derived;
  logic           have;
  logic [1:0]     cur_sev;

  assign exec_bit = |evt_q.prot_word[7:4];
  assign offset   = evt_q.address - reg_rd_q.base;
  assign hit = rrdv_q && (reg_rd_q.source == SRC_WRITE || reg_rd_q.source == SRC_PROT)
               && (evt_q.address >= reg_rd_q.base) && (offset < reg_rd_q.length);
  assign cur_sev = (rec_q.sev == SEV_NONE) ? 2'd0 : rec_q.sev[1:0];

  always_comb begin
    have = 1'b1;
    if (rec_q.flags[F_THREAD] || rec_q.flags[F_MATCH]) begin
      derived = 2'd3;
    end else if (rec_q.flags[F_WRITE] && rec_q.flags[F_PROT]) begin
      derived = 2'd2;
    end else if (rec_q.flags[F_WRITE] || rec_q.flags[F_PROT]) begin
      derived = 2'd1;
    end else begin
      derived = 2'd0;
      have    = rec_q.flags[F_ALLOC];
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    rdv_d     = 1'b0;
    rdidx_d   = rdidx_q;
    ridx_d    = ridx_q;
    rrdv_d    = 1'b0;
    evt_d     = evt_q;
    slot_d    = slot_q;
    rec_d     = rec_q;
    res_d     = res_q;
    ent_we    = 1'b0;
    ent_raddr = idx_q[SW-1:0];
    reg_we    = 1'b0;
    reg_waddr = {slot_q, rec_q.rcount[RW-1:0]};
    reg_raddr = {slot_q, ridx_q[RW-1:0]};
    reg_wdata = '{base: evt_q.address, length: evt_q.region_size, source: SRC_ALLOC};
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          evt_d = in_i.data;
          idx_d = '0;
          if (in_i.data.mode == MODE_NONE) begin
            res_d   = '{status: ST_NO_CHANGE, default: '0};
            state_d = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Walk occupied entries, one read a cycle, compare the last read
      S_SCAN: begin
        if (rdv_q && ent_rd_q.pid == evt_q.pid) begin
          slot_d  = rdidx_q;
          rec_d   = ent_rd_q;
          state_d = S_EXEC;
        end else if (idx_q == fill_q && !rdv_q) begin
          if (fill_q == CW'(TABLE_ENTRIES)) begin
            res_d   = '{status: ST_FULL, default: '0};
            state_d = S_OUT;
          end else begin
            slot_d  = fill_q[SW-1:0];
            rec_d   = '{pid: evt_q.pid, sev: SEV_NONE, default: '0};
            fill_d  = fill_q + 1'b1;
            state_d = S_EXEC;
          end
        end else if (idx_q != fill_q) begin
          rdidx_d = idx_q[SW-1:0];
          rdv_d   = 1'b1;
          idx_d   = idx_q + 1'b1;
        end
      end

      // Apply the event to the entry
      S_EXEC: begin
        state_d = S_EVAL;
        ridx_d  = '0;
        case (evt_q.mode)
          MODE_HOOK: begin
            if (evt_q.address != '0 && evt_q.region_size != '0 &&
                evt_q.api_kind <= API_PROT &&
                rec_q.rcount < RCW'(REGIONS_PER_ENTRY)) begin
              reg_we = 1'b1;
              if (evt_q.api_kind <= API_ALLOC_EX) begin
                reg_wdata.source = SRC_ALLOC;
              end else if (evt_q.api_kind == API_WRITE) begin
                reg_wdata.source = SRC_WRITE;
              end else begin
                reg_wdata.source = SRC_PROT;
              end
              rec_d.rcount = rec_q.rcount + 1'b1;
            end
            if (evt_q.api_kind <= API_ALLOC_EX) begin
              rec_d.flags[F_ALLOC] = 1'b1;
              if (exec_bit) rec_d.flags[F_PROT] = 1'b1;
            end else if (evt_q.api_kind == API_WRITE) begin
              if (rec_q.flags[F_ALLOC]) rec_d.flags[F_WRITE] = 1'b1;
            end else if (evt_q.api_kind <= API_PROT_EX) begin
              if (exec_bit) rec_d.flags[F_PROT] = 1'b1;
            end else if (evt_q.api_kind <= API_THREAD) begin
              rec_d.flags[F_THREAD] = 1'b1;
            end
          end
          MODE_SCAN: begin
            if (rec_q.sev == {1'b0, SEV_CRIT}) begin
              res_d = '{status: ST_LATE, severity: SEV_CRIT, kill_request: 1'b0,
                        chain_step: rec_q.chain, entry_slot: 9'(slot_q)};
              state_d = S_OUT;
            end else if (evt_q.finding_kind <= FIND_REFLECT) begin
              rec_d.flags[F_WRITE] = 1'b1;
              rec_d.flags[F_PROT]  = 1'b1;
            end else if ((evt_q.finding_kind == FIND_CAVE ||
                          evt_q.finding_kind == FIND_STOMP) && evt_q.address != '0) begin
              state_d = S_REGION;
            end else begin
              rec_d.flags[F_PROT] = 1'b1;
            end
          end
          default: begin
            rec_d.flags[F_MATCH] = 1'b1;
          end
        endcase
      end

      // Search recorded write and protect regions for the finding address
      S_REGION: begin
        if (hit) begin
          res_d = '{status: ST_DEDUP, severity: cur_sev, kill_request: 1'b0,
                    chain_step: rec_q.chain, entry_slot: 9'(slot_q)};
          state_d = S_OUT;
        end else if (ridx_q == rec_q.rcount && !rrdv_q) begin
          rec_d.flags[F_PROT] = 1'b1;
          state_d = S_EVAL;
        end else if (ridx_q != rec_q.rcount) begin
          rrdv_d = 1'b1;
          ridx_d = ridx_q + 1'b1;
        end
      end

      // Derive severity, write the entry back, form the result
      S_EVAL: begin
        ent_we = 1'b1;
        if (have && (rec_q.sev == SEV_NONE || {1'b0, derived} > rec_q.sev)) begin
          rec_d.sev   = {1'b0, derived};
          rec_d.chain = (rec_q.chain < CHAIN_MAX) ? rec_q.chain + 1'b1 : rec_q.chain;
          res_d = '{status: ST_VERDICT, severity: derived,
                    kill_request: (derived == SEV_CRIT) && kill_en_q,
                    chain_step: rec_d.chain, entry_slot: 9'(slot_q)};
        end else begin
          res_d = '{status: ST_NO_CHANGE, severity: cur_sev, kill_request: 1'b0,
                    chain_step: rec_q.chain, entry_slot: 9'(slot_q)};
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_o.data = res_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      rdv_q   <= 1'b0;
      rrdv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rdv_q   <= rdv_d;
      rrdv_q  <= rrdv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    rdidx_q <= rdidx_d;
    ridx_q  <= ridx_d;
    evt_q   <= evt_d;
    slot_q  <= slot_d;
    rec_q   <= rec_d;
    res_q   <= res_d;
  end

  // Entry table: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) entry_mem[slot_q] <= rec_d;
    ent_rd_q <= entry_mem[ent_raddr];
  end

  // Region store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (reg_we) region_mem[reg_waddr] <= reg_wdata;
    reg_rd_q <= region_mem[reg_raddr];
  end

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KILL_EN) ? {31'b0, kill_en_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_en_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_KILL_EN) begin
      kill_en_q <= pwdata[0];
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_kill_crit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.kill_request |->
      out_o.data.severity == SEV_CRIT && out_o.data.status == ST_VERDICT)
    else $error("kill request without critical verdict");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status == ST_FULL |->
      out_o.data.entry_slot == '0 && out_o.data.chain_step == '0)
    else $error("full result carries entry data");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready |=> !out_o.valid)
    else $error("result repeated");

endmodule

`default_nettype wire

FILE: tb/sv/process_threat_correlator_tb.sv
// ----------------------------------------------------------------------------
// process_threat_correlator_tb: self-checking regression of the correlator
// Drives hook, scanner and signature events through the valid/ready channel,
// predicts every result item from a local copy of the process table, and
// compares results field by field. Covers region dedup, late evidence,
// kill_enable settings and a completely filled table.
// ----------------------------------------------------------------------------
`default_nettype none

module process_threat_correlator_tb;
  import ptc_pkg::*;

  localparam int unsigned ENTRIES  = 512;
  localparam int unsigned REGIONS  = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned POOL_SIZE   = 32;

  // Codes the package leaves out
  localparam logic [2:0] API_ALLOC     = 3'd0;
  localparam logic [2:0] API_REMOTE    = 3'd5;
  localparam logic [2:0] API_OTHER     = 3'd7;
  localparam logic [2:0] FIND_IMPLANT  = 3'd0;
  localparam logic [2:0] FIND_HOLLOW   = 3'd1;
  localparam logic [2:0] FIND_OTHER    = 3'd5;
  localparam logic [1:0] SEV_LOW_CODE  = 2'd0;
  localparam logic [31:0] EXEC_MASK    = 32'h0000_00F0;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  ptc_evt_if evt_if ();
  ptc_res_if res_if ();

  process_threat_correlator DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (evt_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the process table
  bit          tbl_valid [ENTRIES];
  logic [31:0] tbl_pid   [ENTRIES];
  logic [2:0]  tbl_sev   [ENTRIES];
  logic [4:0]  tbl_flags [ENTRIES];
  int unsigned tbl_nreg  [ENTRIES];
  logic [2:0]  tbl_chain [ENTRIES];
  logic [63:0] rg_base   [ENTRIES][REGIONS];
  logic [63:0] rg_len    [ENTRIES][REGIONS];
  logic [1:0]  rg_src    [ENTRIES][REGIONS];
  bit          kill_en;

  res_t        verdict_q[$];
  int unsigned error_count;
  int unsigned event_count;
  bit          idle_on;
  logic [31:0] pid_pool [POOL_SIZE];
  logic [63:0] last_base;
  logic [63:0] last_size;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Claim or find the entry of a pid; -1 when the table is full
  function automatic int find_slot(logic [31:0] pid);
    int open_slot;
    open_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_pid[i] == pid) return i;
      if (!tbl_valid[i] && open_slot < 0) open_slot = i;
    end
    if (open_slot >= 0) begin
      tbl_valid[open_slot] = 1'b1;
      tbl_pid[open_slot]   = pid;
      tbl_sev[open_slot]   = SEV_NONE;
      tbl_flags[open_slot] = '0;
      tbl_nreg[open_slot]  = 0;
      tbl_chain[open_slot] = '0;
    end
    return open_slot;
  endfunction

  function automatic res_t mk_res(status_e st, logic [1:0] sev, logic kill,
                                  logic [2:0] chain, logic [8:0] slot);
    res_t r;
    r.status       = st;
    r.severity     = sev;
    r.kill_request = kill;
    r.chain_step   = chain;
    r.entry_slot   = slot;
    return r;
  endfunction

  // Expected result of one event; updates the local table
  function automatic res_t predict_verdict(evt_t e);
    int          s;
    bit          exec;
    logic [4:0]  f;
    logic [1:0]  derived;
    bit          have;
    logic [1:0]  cur_sev;
    int unsigned k;
    exec = (e.prot_word & EXEC_MASK) != 0;
    if (e.mode == MODE_NONE) return mk_res(ST_NO_CHANGE, '0, 1'b0, '0, '0);
    s = find_slot(e.pid);
    if (s < 0) return mk_res(ST_FULL, '0, 1'b0, '0, '0);
    cur_sev = (tbl_sev[s] == SEV_NONE) ? SEV_LOW_CODE : tbl_sev[s][1:0];

    if (e.mode == MODE_HOOK) begin
      // record a qualifying region, drop it when the entry is full
      if (e.address != 0 && e.region_size != 0 && e.api_kind <= API_PROT &&
          tbl_nreg[s] < REGIONS) begin
        k = tbl_nreg[s];
        tbl_nreg[s]++;
        rg_base[s][k] = e.address;
        rg_len[s][k]  = e.region_size;
        rg_src[s][k]  = (e.api_kind <= API_ALLOC_EX) ? SRC_ALLOC :
                        (e.api_kind == API_WRITE) ? SRC_WRITE : SRC_PROT;
      end
      if (e.api_kind <= API_ALLOC_EX) begin
        tbl_flags[s][F_ALLOC] = 1'b1;
        if (exec) tbl_flags[s][F_PROT] = 1'b1;
      end else if (e.api_kind == API_WRITE) begin
        if (tbl_flags[s][F_ALLOC]) tbl_flags[s][F_WRITE] = 1'b1;
      end else if (e.api_kind <= API_PROT_EX) begin
        if (exec) tbl_flags[s][F_PROT] = 1'b1;
      end else if (e.api_kind <= API_THREAD) begin
        tbl_flags[s][F_THREAD] = 1'b1;
      end
    end else if (e.mode == MODE_SCAN) begin
      if (tbl_sev[s] == {1'b0, SEV_CRIT})
        return mk_res(ST_LATE, SEV_CRIT, 1'b0, tbl_chain[s], s[8:0]);
      if (e.finding_kind <= FIND_REFLECT) begin
        tbl_flags[s][F_WRITE] = 1'b1;
        tbl_flags[s][F_PROT]  = 1'b1;
      end else if ((e.finding_kind == FIND_CAVE || e.finding_kind == FIND_STOMP) &&
                   e.address != 0) begin
        // findings inside a write or protect region are duplicates
        for (int j = 0; j < tbl_nreg[s]; j++) begin
          if (rg_src[s][j] != SRC_ALLOC && e.address >= rg_base[s][j] &&
              e.address - rg_base[s][j] < rg_len[s][j])
            return mk_res(ST_DEDUP, cur_sev, 1'b0, tbl_chain[s], s[8:0]);
        end
        tbl_flags[s][F_PROT] = 1'b1;
      end else begin
        tbl_flags[s][F_PROT] = 1'b1;
      end
    end else begin
      tbl_flags[s][F_MATCH] = 1'b1;
    end

    // derive severity and report only a rise
    f    = tbl_flags[s];
    have = 1'b1;
    if (f[F_THREAD] || f[F_MATCH]) derived = 2'd3;
    else if (f[F_WRITE] && f[F_PROT]) derived = 2'd2;
    else if (f[F_WRITE] || f[F_PROT]) derived = 2'd1;
    else if (f[F_ALLOC]) derived = 2'd0;
    else begin
      derived = 2'd0;
      have    = 1'b0;
    end
    if (have && (tbl_sev[s] == SEV_NONE || {1'b0, derived} > tbl_sev[s])) begin
      if (tbl_chain[s] < CHAIN_MAX) tbl_chain[s]++;
      tbl_sev[s] = {1'b0, derived};
      return mk_res(ST_VERDICT, derived, (derived == SEV_CRIT) && kill_en,
                    tbl_chain[s], s[8:0]);
    end
    return mk_res(ST_NO_CHANGE, cur_sev, 1'b0, tbl_chain[s], s[8:0]);
  endfunction

  function automatic evt_t mk_evt(logic [1:0] mode, logic [31:0] pid,
                                  logic [2:0] api, logic [2:0] fk, bit exec,
                                  logic [63:0] addr, logic [63:0] size);
    evt_t e;
    e.mode          = mode;
    e.pid           = pid;
    e.api_kind      = api;
    e.finding_kind  = fk;
    e.prot_word     = exec ? ($urandom | (32'h10 << $urandom_range(0, 3)))
                           : ($urandom & ~EXEC_MASK);
    e.address       = addr;
    e.region_size   = size;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return rand64();
      default: return 64'($urandom_range(1, 4096));
    endcase
  endfunction

  // Send one event item; optional idle gap before it
  task automatic send_event(evt_t e);
    int unsigned gap;
    @(negedge clk_i);
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      evt_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    evt_if.valid = 1'b1;
    evt_if.data  = e;
    do @(posedge clk_i); while (!evt_if.ready);
    verdict_q.push_back(predict_verdict(e));
    if (e.mode != MODE_NONE) event_count++;
  endtask

  task automatic hold_events();
    @(negedge clk_i);
    evt_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // APB write of kill_enable, only while the block is idle
  task automatic write_kill_enable(bit value);
    hold_events();
    wait_drained();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 3'(4 * REG_KILL_EN);
    pwdata  = {31'($urandom), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    kill_en = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Directed: field extremes, every hook kind, dedup, late evidence
  task automatic test_directed();
    logic [31:0] pa, pb;
    pa = 32'h0000_0000;
    pb = 32'hFFFF_FFFF;
    send_event(mk_evt(MODE_NONE, 32'h1234_5678, API_OTHER, FIND_OTHER, 1, '1, '1));
    send_event(mk_evt(MODE_HOOK, pa, API_OTHER, FIND_IMPLANT, 0, '0, '0));
    send_event(mk_evt(MODE_HOOK, pa, API_WRITE, 3'd7, 0, 64'h1000, 64'h100));
    send_event(mk_evt(MODE_HOOK, pa, API_ALLOC, 3'd6, 0, '1, '1));
    send_event(mk_evt(MODE_HOOK, pa, API_WRITE, FIND_CAVE, 0, 64'h4000, 64'h100));
    send_event(mk_evt(MODE_SCAN, pa, API_OTHER, FIND_CAVE, 0, 64'h40FF, '0));
    send_event(mk_evt(MODE_SCAN, pa, API_OTHER, FIND_STOMP, 0, 64'h4100, '0));
    send_event(mk_evt(MODE_SCAN, pa, API_OTHER, FIND_CAVE, 0, '0, '0));
    send_event(mk_evt(MODE_HOOK, pb, API_ALLOC_EX, FIND_OTHER, 1, 64'h10, '1));
    send_event(mk_evt(MODE_HOOK, pb, API_PROT, FIND_OTHER, 1, '1, 64'h1));
    send_event(mk_evt(MODE_SCAN, pb, API_OTHER, FIND_STOMP, 0, '1, '0));
    send_event(mk_evt(MODE_HOOK, pb, API_PROT_EX, FIND_OTHER, 0, '0, '0));
    send_event(mk_evt(MODE_HOOK, pb, API_REMOTE, FIND_OTHER, 0, '0, '0));
    send_event(mk_evt(MODE_SCAN, pb, API_OTHER, FIND_IMPLANT, 0, '0, '0));
    send_event(mk_evt(MODE_HOOK, pb, API_THREAD, FIND_OTHER, 0, '0, '0));
    send_event(mk_evt(MODE_SCAN, 32'h5A5A_A5A5, API_OTHER, FIND_HOLLOW, 0, '0, '0));
    send_event(mk_evt(MODE_SCAN, 32'h5A5A_A5A5, API_OTHER, FIND_REFLECT, 0, '0, '0));
    send_event(mk_evt(MODE_SCAN, 32'hA5A5_5A5A, API_OTHER, FIND_OTHER, 0, '0, '0));
    send_event(mk_evt(MODE_SCAN, 32'hA5A5_5A5A, API_OTHER, 3'd6, 0, '0, '0));
    send_event(mk_evt(MODE_MATCH, 32'hA5A5_5A5A, API_OTHER, 3'd7, 0, '0, '0));
  endtask

  // Critical verdicts with kill_enable cleared, then restored
  task automatic test_kill_setting();
    write_kill_enable(1'b0);
    send_event(mk_evt(MODE_MATCH, 32'h0BAD_F00D, API_OTHER, FIND_OTHER, 0, '0, '0));
    send_event(mk_evt(MODE_HOOK, 32'h0BAD_F00E, API_THREAD, FIND_OTHER, 0, '0, '0));
    write_kill_enable(1'b1);
    send_event(mk_evt(MODE_MATCH, 32'h0BAD_F00F, API_OTHER, FIND_OTHER, 0, '0, '0));
  endtask

  // One injection chain on a pooled pid: alloc, write, protect, finding
  task automatic run_injection_chain(logic [31:0] pid);
    logic [63:0] base, size, off;
    base = ($urandom_range(0, 15) == 0) ? '0 : rand64();
    size = ($urandom_range(0, 7) == 0) ? rand_size() : 64'($urandom_range(1, 4096));
    last_base = base;
    last_size = size;
    send_event(mk_evt(MODE_HOOK, pid, 3'($urandom_range(0, 1)), 3'($urandom),
                      $urandom_range(0, 1), base, size));
    if ($urandom_range(0, 3) != 0)
      send_event(mk_evt(MODE_HOOK, pid, API_WRITE, 3'($urandom), 0, base, size));
    if ($urandom_range(0, 1) != 0)
      send_event(mk_evt(MODE_HOOK, pid, 3'($urandom_range(3, 4)), 3'($urandom),
                        $urandom_range(0, 1), base, size));
    off = (size == 0) ? '0 : ($urandom_range(0, 4) == 0) ? size : rand64() % size;
    send_event(mk_evt(MODE_SCAN, pid, 3'($urandom), 3'($urandom_range(3, 4)), 0,
                      base + off, rand64()));
    case ($urandom_range(0, 5))
      0: send_event(mk_evt(MODE_HOOK, pid, 3'($urandom_range(5, 6)), 3'($urandom),
                           0, rand64(), rand64()));
      1: send_event(mk_evt(MODE_MATCH, pid, 3'($urandom), 3'($urandom), 0,
                           rand64(), rand64()));
      2: send_event(mk_evt(MODE_SCAN, pid, 3'($urandom), 3'($urandom), 0,
                           last_base + 64'($urandom_range(0, 8)), rand64()));
      default: ;
    endcase
  endtask

  function automatic evt_t noise_event();
    evt_t e;
    e.mode          = 2'($urandom);
    e.pid           = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : pid_pool[$urandom_range(0, POOL_SIZE - 1)];
    e.api_kind      = 3'($urandom);
    e.finding_kind  = 3'($urandom);
    e.prot_word     = $urandom;
    e.address       = ($urandom_range(0, 3) == 0) ? last_base + 64'($urandom_range(0, 64))
                                                  : rand64();
    e.region_size   = rand_size();
    return e;
  endfunction

  // Random phases; kill_enable changes between them with the block drained
  task automatic test_random(int unsigned n_items);
    int unsigned stop;
    for (int ph = 0; ph < 4; ph++) begin
      stop = event_count + n_items / 4;
      while (event_count < stop) begin
        if ($urandom_range(0, 3) != 0)
          run_injection_chain(pid_pool[$urandom_range(0, POOL_SIZE - 1)]);
        else
          send_event(noise_event());
      end
      write_kill_enable(ph[0]);
    end
    write_kill_enable(1'b1);
  endtask

  // Fill the table with fresh pids, then hit it with a full table
  task automatic test_table_full();
    int unsigned used;
    idle_on = 1'b0;
    used = 0;
    for (int i = 0; i < ENTRIES; i++) used += tbl_valid[i];
    while (used < ENTRIES) begin
      send_event(mk_evt(2'($urandom_range(0, 2)), $urandom, 3'($urandom),
                        3'($urandom), $urandom_range(0, 1), rand64(), rand_size()));
      used = 0;
      for (int i = 0; i < ENTRIES; i++) used += tbl_valid[i];
    end
    for (int i = 0; i < 20; i++) begin
      if (i[0])
        send_event(mk_evt(2'($urandom), $urandom, 3'($urandom), 3'($urandom),
                          $urandom_range(0, 1), rand64(), rand_size()));
      else
        send_event(noise_event());
    end
  endtask

  // Result ready with random stall bursts
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        res_if.ready = 1'b1;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (verdict_q.size() == 0) begin
        $error("unexpected result item %p", got);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          error_count++;
        end
        if (got.severity !== want.severity) begin
          $error("severity: expected %0d, actual %0d", want.severity, got.severity);
          error_count++;
        end
        if (got.kill_request !== want.kill_request) begin
          $error("kill_request: expected %0d, actual %0d",
                 want.kill_request, got.kill_request);
          error_count++;
        end
        if (got.chain_step !== want.chain_step) begin
          $error("chain_step: expected %0d, actual %0d",
                 want.chain_step, got.chain_step);
          error_count++;
        end
        if (got.entry_slot !== want.entry_slot) begin
          $error("entry_slot: expected %0d, actual %0d",
                 want.entry_slot, got.entry_slot);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("process_threat_correlator regression: fail");
        $finish;
      end
    end
  end

  // Sequence of tests
  initial begin
    evt_if.valid = 1'b0;
    evt_if.data  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_ni       = 1'b0;
    kill_en      = 1'b1;
    idle_on      = 1'b1;
    error_count  = 0;
    event_count  = 0;
    last_base    = '0;
    last_size    = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) pid_pool[i] = $urandom;
    pid_pool[0] = 32'h0000_0000;
    pid_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_kill_setting();
    test_random(300);
    test_table_full();

    hold_events();
    wait_drained();
    repeat (600) @(posedge clk_i);
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("process_threat_correlator regression: pass");
    end else begin
      $display("process_threat_correlator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/ptc_pkg.sv
sv/ptc_if.sv
sv/process_threat_correlator.sv
tb/sv/process_threat_correlator_tb.sv
